### src/dcdr_pkg.sv
// shared types, constants and helper functions of the day count date register
// no dependencies; imported by every module of the block
`default_nettype none

package dcdr_pkg;

    localparam int COUNT_W  = 22;                  // day count width
    localparam int ACC_W    = 23;                  // holds an unclipped date sum
    localparam int YIN_W    = 14;                  // year field width
    localparam int MON_W    = 4;                   // month field width
    localparam int DAY_W    = 5;                   // day field width
    localparam int ACT_W    = 3;                   // action code width
    localparam int UPC_W    = 4;                   // microcode address width
    localparam int YLEN_W   = 9;                   // year length width
    localparam int MAX_YEAR_DEF = 9999;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [MON_W-1:0]   LAST_MONTH = 4'd11;
    localparam logic [MON_W-1:0]   YEAR_MONTHS = 4'd12;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_COUNT = 3'd0,
        ACT_LOAD_DATE  = 3'd1,
        ACT_INC        = 3'd2,
        ACT_DEC        = 3'd3,
        ACT_ADD        = 3'd4,
        ACT_SUB        = 3'd5
    } act_t;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_APPLY,
        ALU_CLEAR,
        ALU_ADD_YEAR,
        ALU_ADD_MONTH,
        ALU_ADD_DAY,
        ALU_SAT,
        ALU_SUB_YEAR,
        ALU_SUB_MONTH,
        ALU_EMIT
    } alu_op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_NO_INPUT,
        C_NOT_DATE,
        C_YEARS_DONE,
        C_MONTHS_DONE,
        C_YEAR_SHORT,
        C_MONTH_SHORT,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic              take;   // input channel open in this step
        cond_t             cond;
        logic [UPC_W-1:0]  jump;   // taken when cond holds, op skipped
        logic [UPC_W-1:0]  next;   // otherwise op runs and control goes here
        alu_op_t           op;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        logic    en;
        alu_op_t op;
    } ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic not_date;
        logic years_done;
        logic months_done;
        logic year_short;
        logic month_short;
        logic out_busy;
    } stat_t;

    // microcode addresses
    localparam logic [UPC_W-1:0] UA_FETCH  = 4'd0;
    localparam logic [UPC_W-1:0] UA_DISP   = 4'd1;
    localparam logic [UPC_W-1:0] UA_YEARS  = 4'd2;
    localparam logic [UPC_W-1:0] UA_MONTHS = 4'd3;
    localparam logic [UPC_W-1:0] UA_DAYS   = 4'd4;
    localparam logic [UPC_W-1:0] UA_SAT    = 4'd5;
    localparam logic [UPC_W-1:0] UA_WALK_Y = 4'd6;
    localparam logic [UPC_W-1:0] UA_WALK_M = 4'd7;
    localparam logic [UPC_W-1:0] UA_EMIT   = 4'd8;

    function automatic logic [DAY_W-1:0] month_len_f(input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd1:                      len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // last day of year max_year+1, limited to the count range
    function automatic logic [COUNT_W-1:0] day_max_f(input int max_year);
        longint n;
        longint lim;
        begin
            n   = longint'(max_year) + 64'sd1;
            lim = 365 * n + n / 4 - n / 100 + n / 400 - 1;
            if (lim > longint'(COUNT_MAX))
                lim = longint'(COUNT_MAX);
            return lim[COUNT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### src/dcdr_seq.sv
// microcode sequencer: step counter, control store and jump logic
// depends on dcdr_pkg
`default_nettype none

module dcdr_seq
    import dcdr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire stat_t stat,
    output logic       in_ready,
    output ctl_t       ctl
);

    function automatic ucode_t urom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        begin
            unique case (addr)
                UA_FETCH:  w = '{1'b1, C_NO_INPUT,    UA_FETCH,  UA_DISP,   ALU_APPLY};
                UA_DISP:   w = '{1'b0, C_NOT_DATE,    UA_SAT,    UA_YEARS,  ALU_CLEAR};
                UA_YEARS:  w = '{1'b0, C_YEARS_DONE,  UA_MONTHS, UA_YEARS,  ALU_ADD_YEAR};
                UA_MONTHS: w = '{1'b0, C_MONTHS_DONE, UA_DAYS,   UA_MONTHS, ALU_ADD_MONTH};
                UA_DAYS:   w = '{1'b0, C_NEVER,       UA_SAT,    UA_SAT,    ALU_ADD_DAY};
                UA_SAT:    w = '{1'b0, C_NEVER,       UA_WALK_Y, UA_WALK_Y, ALU_SAT};
                UA_WALK_Y: w = '{1'b0, C_YEAR_SHORT,  UA_WALK_M, UA_WALK_Y, ALU_SUB_YEAR};
                UA_WALK_M: w = '{1'b0, C_MONTH_SHORT, UA_EMIT,   UA_WALK_M, ALU_SUB_MONTH};
                UA_EMIT:   w = '{1'b0, C_OUT_BUSY,    UA_EMIT,   UA_FETCH,  ALU_EMIT};
                default:   w = '{1'b0, C_NEVER,       UA_FETCH,  UA_FETCH,  ALU_NOP};
            endcase
            return w;
        end
    endfunction

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    ucode_t           word;
    logic             hit;

    assign word = urom(upc_reg);

    always_comb
    begin
        unique case (word.cond)
            C_NO_INPUT:    hit = !in_valid;
            C_NOT_DATE:    hit = stat.not_date;
            C_YEARS_DONE:  hit = stat.years_done;
            C_MONTHS_DONE: hit = stat.months_done;
            C_YEAR_SHORT:  hit = stat.year_short;
            C_MONTH_SHORT: hit = stat.month_short;
            C_OUT_BUSY:    hit = stat.out_busy;
            default:       hit = 1'b0;
        endcase
        upc_next = hit ? word.jump : word.next;
        ctl.en   = !hit;
        ctl.op   = word.op;
        in_ready = word.take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UA_FETCH;
        else
            upc_reg <= upc_next;
    end

endmodule

`default_nettype wire

### src/dcdr_datapath.sv
// datapath: running count, accumulator, year and month walkers, output register
// depends on dcdr_pkg; driven by dcdr_seq control words
`default_nettype none

module dcdr_datapath
    import dcdr_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctl_t               ctl,
    output stat_t                   stat,
    input  wire logic [ACT_W-1:0]   action,
    input  wire logic [COUNT_W-1:0] operand_days,
    input  wire logic [YIN_W-1:0]   year_in,
    input  wire logic [MON_W-1:0]   month_in,
    input  wire logic [DAY_W-1:0]   day_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [COUNT_W-1:0]      total_days,
    output logic [YIN_W-1:0]        years_out,
    output logic [MON_W-1:0]        months_out,
    output logic [DAY_W-1:0]        days_out,
    output logic                    clipped
);

    localparam int YW_RAW = $clog2(MAX_YEAR + 2);
    localparam int YEAR_W = (YW_RAW > YIN_W) ? YW_RAW : YIN_W;
    localparam logic [COUNT_W-1:0] DAY_MAX = day_max_f(MAX_YEAR);
    localparam logic [ACC_W-1:0]   ACC_MAX = ACC_W'(DAY_MAX);

    logic [COUNT_W-1:0] day_total_reg, day_total_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [YEAR_W-1:0]  yrs_reg, yrs_next;
    logic [1:0]         m4_reg, m4_next;
    logic [6:0]         m100_reg, m100_next;
    logic [8:0]         m400_reg, m400_next;
    logic [MON_W-1:0]   mon_reg, mon_next;
    logic               clip_reg, clip_next;
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [YIN_W-1:0]   yin_reg, yin_next;
    logic [MON_W-1:0]   mtgt_reg, mtgt_next;
    logic [DAY_W-1:0]   din_reg, din_next;
    logic               ovalid_reg, ovalid_next;
    logic [COUNT_W-1:0] ototal_reg, ototal_next;
    logic [YIN_W-1:0]   oyrs_reg, oyrs_next;
    logic [MON_W-1:0]   omon_reg, omon_next;
    logic [DAY_W-1:0]   oday_reg, oday_next;
    logic               oclip_reg, oclip_next;

    logic               leap;
    logic [YLEN_W-1:0]  ylen;
    logic [DAY_W-1:0]   mlen;
    logic [ACC_W-1:0]   t_ext;
    logic [ACC_W-1:0]   opd_ext;

    // leap rule of the year being walked, from its residues
    assign leap = (m400_reg == 9'd0) || ((m4_reg == 2'd0) && (m100_reg != 7'd0));
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_len_f(mon_reg, leap);
    assign t_ext   = ACC_W'(day_total_reg);
    assign opd_ext = ACC_W'(operand_days);

    always_comb
    begin
        stat.not_date    = act_reg != ACT_LOAD_DATE;
        stat.years_done  = yrs_reg == YEAR_W'(yin_reg);
        stat.months_done = mon_reg == mtgt_reg;
        stat.year_short  = acc_reg < ACC_W'(ylen);
        stat.month_short = (mon_reg == LAST_MONTH) || (acc_reg < ACC_W'(mlen));
        stat.out_busy    = ovalid_reg && !out_ready;
    end

    always_comb
    begin
        day_total_next = day_total_reg;
        acc_next       = acc_reg;
        yrs_next       = yrs_reg;
        m4_next        = m4_reg;
        m100_next      = m100_reg;
        m400_next      = m400_reg;
        mon_next       = mon_reg;
        clip_next      = clip_reg;
        act_next       = act_reg;
        yin_next       = yin_reg;
        mtgt_next      = mtgt_reg;
        din_next       = din_reg;
        ovalid_next    = ovalid_reg && !out_ready;
        ototal_next    = ototal_reg;
        oyrs_next      = oyrs_reg;
        omon_next      = omon_reg;
        oday_next      = oday_reg;
        oclip_next     = oclip_reg;

        if (ctl.en)
        begin
            case (ctl.op)
                ALU_APPLY:
                begin
                    act_next  = action;
                    yin_next  = year_in;
                    mtgt_next = (month_in > YEAR_MONTHS) ? YEAR_MONTHS : month_in;
                    din_next  = day_in;
                    clip_next = 1'b0;
                    case (action)
                        ACT_LOAD_COUNT: acc_next = opd_ext;
                        ACT_INC:        acc_next = t_ext + ACC_W'(1);
                        ACT_DEC:
                        begin
                            if (day_total_reg == '0)
                            begin
                                acc_next  = '0;
                                clip_next = 1'b1;
                            end
                            else
                                acc_next = t_ext - ACC_W'(1);
                        end
                        ACT_ADD:        acc_next = t_ext + opd_ext;
                        ACT_SUB:
                        begin
                            if (operand_days > day_total_reg)
                            begin
                                acc_next  = '0;
                                clip_next = 1'b1;
                            end
                            else
                                acc_next = t_ext - opd_ext;
                        end
                        default:        acc_next = t_ext;
                    endcase
                end
                ALU_CLEAR:
                begin
                    acc_next  = '0;
                    yrs_next  = '0;
                    m4_next   = 2'd1;
                    m100_next = 7'd1;
                    m400_next = 9'd1;
                    mon_next  = '0;
                end
                ALU_ADD_YEAR, ALU_SUB_YEAR:
                begin
                    if (ctl.op == ALU_ADD_YEAR)
                        acc_next = acc_reg + ACC_W'(ylen);
                    else
                        acc_next = acc_reg - ACC_W'(ylen);
                    yrs_next  = yrs_reg + YEAR_W'(1);
                    m4_next   = m4_reg + 2'd1;
                    m100_next = (m100_reg == 7'd99) ? 7'd0 : m100_reg + 7'd1;
                    m400_next = (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
                end
                ALU_ADD_MONTH:
                begin
                    acc_next = acc_reg + ACC_W'(mlen);
                    mon_next = mon_reg + 4'd1;
                end
                ALU_SUB_MONTH:
                begin
                    acc_next = acc_reg - ACC_W'(mlen);
                    mon_next = mon_reg + 4'd1;
                end
                ALU_ADD_DAY:
                    acc_next = acc_reg + ACC_W'(din_reg);
                ALU_SAT:
                begin
                    if (acc_reg > ACC_MAX)
                    begin
                        acc_next       = ACC_MAX;
                        clip_next      = 1'b1;
                        day_total_next = DAY_MAX;
                    end
                    else
                        day_total_next = acc_reg[COUNT_W-1:0];
                    yrs_next  = '0;
                    m4_next   = 2'd1;
                    m100_next = 7'd1;
                    m400_next = 9'd1;
                    mon_next  = '0;
                end
                ALU_EMIT:
                begin
                    ovalid_next = 1'b1;
                    ototal_next = day_total_reg;
                    oyrs_next   = yrs_reg[YIN_W-1:0];
                    omon_next   = mon_reg;
                    oday_next   = acc_reg[DAY_W-1:0];
                    oclip_next  = clip_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_total_reg <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            day_total_reg <= day_total_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        yrs_reg    <= yrs_next;
        m4_reg     <= m4_next;
        m100_reg   <= m100_next;
        m400_reg   <= m400_next;
        mon_reg    <= mon_next;
        clip_reg   <= clip_next;
        act_reg    <= act_next;
        yin_reg    <= yin_next;
        mtgt_reg   <= mtgt_next;
        din_reg    <= din_next;
        ototal_reg <= ototal_next;
        oyrs_reg   <= oyrs_next;
        omon_reg   <= omon_next;
        oday_reg   <= oday_next;
        oclip_reg  <= oclip_next;
    end

    assign out_valid  = ovalid_reg;
    assign total_days = ototal_reg;
    assign years_out  = oyrs_reg;
    assign months_out = omon_reg;
    assign days_out   = oday_reg;
    assign clipped    = oclip_reg;

endmodule

`default_nettype wire

### src/day_count_date_register.sv
// top level of the day count date register: sequencer plus datapath
// depends on dcdr_pkg, dcdr_seq, dcdr_datapath
//
// channel | handshake             | payload
// --------+-----------------------+------------------------------------------------
// in      | in_valid / in_ready   | action, operand_days, year_in, month_in, day_in
// out     | out_valid / out_ready | total_days, years_out, months_out, days_out,
//         |                       | clipped
//
// a transaction walks the count into years, then months; a load date first adds
// year_in years, month_in months (limited to 12) and day_in days to the accumulator
// the year walk of the shared accumulator, one year per cycle, is the longest part
// reset: rst_n clears the day count to zero, the step counter and the output valid
// in_ready is high only in the fetch step; a result waits in the output register
// and the next transaction is taken meanwhile; a stalled output holds the emit step
`default_nettype none

module day_count_date_register
    import dcdr_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ACT_W-1:0]   action,
    input  wire logic [COUNT_W-1:0] operand_days,
    input  wire logic [YIN_W-1:0]   year_in,
    input  wire logic [MON_W-1:0]   month_in,
    input  wire logic [DAY_W-1:0]   day_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [COUNT_W-1:0]      total_days,
    output logic [YIN_W-1:0]        years_out,
    output logic [MON_W-1:0]        months_out,
    output logic [DAY_W-1:0]        days_out,
    output logic                    clipped
);

    localparam logic [COUNT_W-1:0] DAY_MAX = day_max_f(MAX_YEAR);

    ctl_t  ctl;     // control word fields for the datapath
    stat_t stat;    // jump conditions back to the sequencer

    // program counter, control store and jump select
    dcdr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_ready (in_ready),
        .ctl      (ctl)
    );

    // count update, saturation, date walk and output register
    dcdr_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .action       (action),
        .operand_days (operand_days),
        .year_in      (year_in),
        .month_in     (month_in),
        .day_in       (day_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .total_days   (total_days),
        .years_out    (years_out),
        .months_out   (months_out),
        .days_out     (days_out),
        .clipped      (clipped)
    );

    // the count never leaves the saturated range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total_days <= DAY_MAX)
        else $error("count above limit");

    // month walk stops by the last month and the day remainder fits a month
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (months_out <= LAST_MONTH) && (days_out <= 5'd30))
        else $error("date field out of range");

    // saturation lands on one of the two ends
    a_clip_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (total_days == '0) || (total_days == DAY_MAX))
        else $error("clipped count not at an end");

    // one transaction at a time through the sequencer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench of day_count_date_register: a directed table, then random traffic
// depends on dcdr_pkg and the day_count_date_register top level; expected dates come from
// an in-bench model of the gregorian day count split
`default_nettype none

module tb;

    import dcdr_pkg::*;

    // ------------------------------------------------------------------
    // run shape
    // ------------------------------------------------------------------
    localparam int MAX_YEAR      = MAX_YEAR_DEF;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 75;
    localparam int FILL_AT       = 30;      // start of the back-pressure burst
    localparam int FILL_LEN      = 10;      // back-to-back transactions while output is held
    localparam int PAUSE_AT      = 55;      // sender waits for an empty pipe here
    localparam int CALM_AT       = 60;      // no idling on either side from here on
    localparam int LONG_HOLD     = 300;     // receiver hold-off in cycles
    localparam int SMALL_SPAN    = 60000;   // counts below this keep a transaction short
    localparam int SMALL_YEARS   = 120;
    localparam logic [YIN_W-1:0] YEAR_ALL = {YIN_W{1'b1}};
    localparam int FINAL_WAIT    = 200000;  // bound on the wait for the last results
    localparam int TAIL_CYCLES   = 64;
    localparam int MAX_REPORTS   = 40;

    // unused action codes, the block must leave the count alone
    localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

    // directed rows either carry a typed result or defer to the model
    localparam logic FIXED = 1'b1;
    localparam logic PRED  = 1'b0;

    // ------------------------------------------------------------------
    // transaction types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COUNT_W-1:0] operand_days;
        logic [YIN_W-1:0]   year_in;
        logic [MON_W-1:0]   month_in;
        logic [DAY_W-1:0]   day_in;
    } day_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] total_days;
        logic [YIN_W-1:0]   years;
        logic [MON_W-1:0]   months;
        logic [DAY_W-1:0]   days;
        logic               clipped;
    } date_rec_t;

    typedef struct packed {
        day_cmd_t  cmd;
        logic      has_want;
        date_rec_t want;
    } dir_row_t;

    // ------------------------------------------------------------------
    // calendar arithmetic
    // ------------------------------------------------------------------
    function automatic logic leap_year(input longint unsigned y);
        return ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
    endfunction

    // days in years 1..n
    function automatic longint unsigned years_span(input longint unsigned n);
        return 365 * n + n / 4 - n / 100 + n / 400;
    endfunction

    function automatic longint unsigned month_days(input int unsigned m, input logic leap);
        longint unsigned len;
        case (m)
            1:          len = leap ? 29 : 28;
            3, 5, 8, 10: len = 30;
            default:    len = 31;
        endcase
        return len;
    endfunction

    // last valid count: final day of year MAX_YEAR+1, kept inside the count range
    localparam longint unsigned SPAN_END = years_span(MAX_YEAR + 1) - 1;
    localparam logic [COUNT_W-1:0] DAY_LIMIT =
        (SPAN_END > longint'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(SPAN_END);
    localparam logic [YIN_W-1:0] MAX_YR = YIN_W'(MAX_YEAR);

    // new count after one transaction, split into years, months and days
    function automatic date_rec_t date_after(input day_cmd_t c, input logic [COUNT_W-1:0] held);
        longint unsigned nxt;
        longint unsigned rem;
        longint unsigned yrs;
        int unsigned mon;
        int unsigned mlim;
        logic leap;
        date_rec_t r;
        nxt = held;
        r = '0;
        case (c.action)
            ACT_LOAD_COUNT:
                nxt = c.operand_days;
            ACT_LOAD_DATE:
            begin
                // month field above a year counts as a full year of months
                leap = leap_year(longint'(c.year_in) + 1);
                mlim = (c.month_in > YEAR_MONTHS) ? YEAR_MONTHS : c.month_in;
                nxt = years_span(c.year_in);
                for (mon = 0; mon < mlim; mon++)
                    nxt += month_days(mon, leap);
                nxt += c.day_in;
            end
            ACT_INC:
                nxt = longint'(held) + 1;
            ACT_DEC:
                if (held == 0)
                    r.clipped = 1'b1;
                else
                    nxt = longint'(held) - 1;
            ACT_ADD:
                nxt = longint'(held) + longint'(c.operand_days);
            ACT_SUB:
                if (c.operand_days > held)
                begin
                    r.clipped = 1'b1;
                    nxt = 0;
                end
                else
                    nxt = longint'(held) - longint'(c.operand_days);
            default:
                ;
        endcase
        if (nxt > DAY_LIMIT)
        begin
            nxt = DAY_LIMIT;
            r.clipped = 1'b1;
        end
        // walk whole years, then whole months of the year reached
        rem = nxt;
        yrs = 0;
        while (rem >= (leap_year(yrs + 1) ? 366 : 365))
        begin
            rem -= leap_year(yrs + 1) ? 366 : 365;
            yrs++;
        end
        leap = leap_year(yrs + 1);
        mon = 0;
        while (mon < LAST_MONTH && rem >= month_days(mon, leap))
        begin
            rem -= month_days(mon, leap);
            mon++;
        end
        r.total_days = COUNT_W'(nxt);
        r.years      = YIN_W'(yrs);
        r.months     = MON_W'(mon);
        r.days       = DAY_W'(rem);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // dut
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [ACT_W-1:0]   action;
    logic [COUNT_W-1:0] operand_days;
    logic [YIN_W-1:0]   year_in;
    logic [MON_W-1:0]   month_in;
    logic [DAY_W-1:0]   day_in;
    logic               out_valid;
    logic               out_ready;
    logic [COUNT_W-1:0] total_days;
    logic [YIN_W-1:0]   years_out;
    logic [MON_W-1:0]   months_out;
    logic [DAY_W-1:0]   days_out;
    logic               clipped;

    day_count_date_register #(
        .MAX_YEAR     (MAX_YEAR)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .operand_days (operand_days),
        .year_in      (year_in),
        .month_in     (month_in),
        .day_in       (day_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .total_days   (total_days),
        .years_out    (years_out),
        .months_out   (months_out),
        .days_out     (days_out),
        .clipped      (clipped)
    );

    // ------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------
    date_rec_t          due_dates[$];       // results owed by the block, oldest first
    dir_row_t           dir_rows[$];        // directed stimulus table
    logic [COUNT_W-1:0] held_days = '0;     // model copy of the running count
    int                 mismatches = 0;
    int                 hold_requests = 0;  // bumped by the sender to ask for a long hold-off
    logic               quiet_tail = 1'b0;  // last stretch: no idling anywhere

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
            flag_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    task automatic add_row(input logic [ACT_W-1:0] act, input logic [COUNT_W-1:0] opd,
                           input logic [YIN_W-1:0] yr, input logic [MON_W-1:0] mo,
                           input logic [DAY_W-1:0] dy, input logic has_want,
                           input logic [COUNT_W-1:0] tot, input logic [YIN_W-1:0] yrs,
                           input logic [MON_W-1:0] mos, input logic [DAY_W-1:0] dys,
                           input logic clp);
        dir_row_t row;
        row.cmd       = '{action: act, operand_days: opd, year_in: yr, month_in: mo,
                          day_in: dy};
        row.has_want  = has_want;
        row.want      = '{total_days: tot, years: yrs, months: mos, days: dys,
                          clipped: clp};
        dir_rows.push_back(row);
    endtask

    // offer one transaction and hold it until the block takes it; called right after
    // a rising edge, so the new payload and valid land on that edge
    task automatic send_cmd(input day_cmd_t c, input logic has_want, input date_rec_t want);
        date_rec_t got;
        in_valid     <= 1'b1;
        action       <= c.action;
        operand_days <= c.operand_days;
        year_in      <= c.year_in;
        month_in     <= c.month_in;
        day_in       <= c.day_in;
        do
            @(posedge clk);
        while (!in_ready);
        // accepted on this edge: advance the model and queue what must come out
        got = date_after(c, held_days);
        held_days = got.total_days;
        due_dates.push_back(has_want ? want : got);
    endtask

    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // random transaction; counts are kept small apart from the odd large one, since
    // the block spends a cycle per elapsed year
    function automatic day_cmd_t random_cmd(input logic allow_big,
                                            input logic [COUNT_W-1:0] held);
        day_cmd_t c;
        logic big;
        int unsigned pick;
        // fields the action ignores still carry noise
        c.action       = ACT_LOAD_COUNT;
        c.operand_days = COUNT_W'($urandom);
        c.year_in      = YIN_W'($urandom);
        c.month_in     = MON_W'($urandom);
        c.day_in       = DAY_W'($urandom);
        big  = allow_big && ($urandom_range(0, 14) == 0);
        pick = $urandom_range(0, 19);
        // a large count slows every later transaction, so bring it back down
        if (!big && held > SMALL_SPAN)
            pick = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 4 : 16);
        if (pick < 4)
        begin
            c.action = ACT_LOAD_COUNT;
            c.operand_days = big ? COUNT_W'($urandom_range(DAY_LIMIT - 2000, COUNT_MAX))
                                 : COUNT_W'($urandom_range(0, SMALL_SPAN));
        end
        else if (pick < 7)
        begin
            c.action  = ACT_LOAD_DATE;
            c.year_in = big ? YIN_W'($urandom_range(MAX_YEAR - 50, YEAR_ALL))
                            : YIN_W'($urandom_range(0, SMALL_YEARS));
        end
        else if (pick < 10)
            c.action = ACT_INC;
        else if (pick < 13)
            c.action = ACT_DEC;
        else if (pick < 16)
        begin
            c.action = ACT_ADD;
            if (!big)
                c.operand_days = COUNT_W'($urandom_range(0, 3000));
        end
        else if (pick < 19)
        begin
            c.action = ACT_SUB;
            if (!big && held > SMALL_SPAN)
                c.operand_days = held - COUNT_W'($urandom_range(0, 3000));
            else if (!big)
                c.operand_days = COUNT_W'($urandom_range(0, held + 40));
        end
        else
            c.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_A : ACT_SPARE_B;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // receiver: checks each result transaction and drives out_ready
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int holds_granted;
        logic rdy;
        date_rec_t want;
        stall_left = 0;
        holds_granted = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (due_dates.size() == 0)
                    flag_mismatch($sformatf("result %0d with no transaction pending",
                                            total_days));
                else
                begin
                    want = due_dates.pop_front();
                    check_field("total_days", want.total_days, total_days);
                    check_field("years_out",  want.years,      years_out);
                    check_field("months_out", want.months,     months_out);
                    check_field("days_out",   want.days,       days_out);
                    check_field("clipped",    want.clipped,    clipped);
                end
            end
            // long hold-off on request, so the block backs up into its input
            if (hold_requests != holds_granted)
            begin
                holds_granted++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                // burst of stalled cycles, its length drawn at random
                stall_left = $urandom_range(0, 3);
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            out_ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        day_cmd_t cmd;
        date_rec_t no_want;
        int n;
        int waited;

        no_want = '0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_LOAD_COUNT;
        operand_days <= '0;
        year_in      <= '0;
        month_in     <= '0;
        day_in       <= '0;

        // directed table: typed results only where they are obvious
        //      action          operand    year     mon  day  check  total      years   mon   day clip
        // decrement straight after reset saturates at zero
        add_row(ACT_DEC,        0,         0,       0,   0,   FIXED, 0,         0,      0,    0,  1);
        add_row(ACT_INC,        0,         0,       0,   0,   FIXED, 1,         0,      0,    1,  0);
        add_row(ACT_LOAD_COUNT, 0,         0,       0,   0,   FIXED, 0,         0,      0,    0,  0);
        // top of the range is dec 31 of the last year
        add_row(ACT_LOAD_COUNT, DAY_LIMIT, 0,       0,   0,   FIXED, DAY_LIMIT, MAX_YR, 11,   30, 0);
        add_row(ACT_INC,        0,         0,       0,   0,   FIXED, DAY_LIMIT, MAX_YR, 11,   30, 1);
        add_row(ACT_ADD,        COUNT_MAX, 0,       0,   0,   FIXED, DAY_LIMIT, MAX_YR, 11,   30, 1);
        add_row(ACT_LOAD_COUNT, COUNT_MAX, 0,       0,   0,   FIXED, DAY_LIMIT, MAX_YR, 11,   30, 1);
        add_row(ACT_SUB,        COUNT_MAX, 0,       0,   0,   FIXED, 0,         0,      0,    0,  1);
        add_row(ACT_LOAD_DATE,  0,         0,       0,   0,   FIXED, 0,         0,      0,    0,  0);
        add_row(ACT_LOAD_DATE,  0,         MAX_YR,  11,  30,  FIXED, DAY_LIMIT, MAX_YR, 11,   30, 0);
        // date far past the range saturates
        add_row(ACT_LOAD_DATE,  0,         YEAR_ALL, 15, 31,  FIXED, DAY_LIMIT, MAX_YR, 11,   30, 1);
        // month field of exactly a year and above a year
        add_row(ACT_LOAD_DATE,  0,         0,       12,  0,   PRED,  0,         0,      0,    0,  0);
        add_row(ACT_LOAD_DATE,  0,         0,       15,  0,   PRED,  0,         0,      0,    0,  0);
        // feb 29 in a leap year, spills to march in a century year, held in year 400
        add_row(ACT_LOAD_DATE,  0,         3,       1,   28,  PRED,  0,         0,      0,    0,  0);
        add_row(ACT_LOAD_DATE,  0,         99,      1,   28,  PRED,  0,         0,      0,    0,  0);
        add_row(ACT_LOAD_DATE,  0,         399,     1,   28,  PRED,  0,         0,      0,    0,  0);
        add_row(ACT_LOAD_COUNT, 59,        0,       0,   0,   PRED,  0,         0,      0,    0,  0);
        add_row(ACT_DEC,        0,         0,       0,   0,   PRED,  0,         0,      0,    0,  0);
        add_row(ACT_ADD,        1000,      0,       0,   0,   PRED,  0,         0,      0,    0,  0);
        add_row(ACT_SUB,        500,       0,       0,   0,   PRED,  0,         0,      0,    0,  0);
        // unused actions with every payload bit set, then clear
        add_row(ACT_SPARE_A,    COUNT_MAX, YEAR_ALL, 15, 31,  PRED,  0,         0,      0,    0,  0);
        add_row(ACT_SPARE_B,    0,         0,       0,   0,   PRED,  0,         0,      0,    0,  0);
        add_row(ACT_LOAD_COUNT, 1460,      0,       0,   0,   PRED,  0,         0,      0,    0,  0);
        // subtract one past the count
        add_row(ACT_SUB,        1461,      0,       0,   0,   FIXED, 0,         0,      0,    0,  1);
        add_row(ACT_LOAD_COUNT, 365,       0,       0,   0,   PRED,  0,         0,      0,    0,  0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            send_cmd(dir_rows[k].cmd, dir_rows[k].has_want, dir_rows[k].want);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 4));
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_tail = (n >= CALM_AT);
            // ask the receiver to hold off while short transactions pile up
            if (n == FILL_AT)
                hold_requests++;
            // once, let the pipe run dry before going on
            if (n == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (due_dates.size() != 0);
            end
            cmd = random_cmd(!(n >= FILL_AT && n < FILL_AT + FILL_LEN), held_days);
            send_cmd(cmd, PRED, no_want);
            if (!quiet_tail && !(n >= FILL_AT && n < FILL_AT + FILL_LEN)
                && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 4));
        end
        in_valid <= 1'b0;

        // drain: every owed result must show up, then nothing more may
        waited = 0;
        while (due_dates.size() != 0 && waited < FINAL_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (due_dates.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", due_dates.size()));
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[day_count_date_register] OK");
        else
            $display("[day_count_date_register] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial
    begin
        #(64'd200_000_000);
        $display("[day_count_date_register] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### day_count_date_register.f
src/dcdr_pkg.sv
src/dcdr_seq.sv
src/dcdr_datapath.sv
src/day_count_date_register.sv
dv/tb.sv
